### src/rme_pkg.sv
`default_nettype none
package rme_pkg;
	localparam int QW = 16;
	localparam int VW = QW + 1;
	localparam int Q14 = 14;
	localparam int ANG_W = 32;
	localparam int CW = 40;
	localparam logic signed [ANG_W-1:0] ANG_90 = 32'sd2949120;
	localparam logic signed [ANG_W-1:0] ANG_LIMIT = 32'sd23040;
	localparam logic [4:0] REG_TOL = 5'd0;
	localparam logic [4:0] REG_SING = 5'd1;

	function automatic logic signed [ANG_W-1:0] atan_tab(input logic [4:0] i);
		case (i)
			5'd0: atan_tab = 32'sd1474560;
			5'd1: atan_tab = 32'sd870484;
			5'd2: atan_tab = 32'sd459940;
			5'd3: atan_tab = 32'sd233473;
			5'd4: atan_tab = 32'sd117189;
			5'd5: atan_tab = 32'sd58652;
			5'd6: atan_tab = 32'sd29333;
			5'd7: atan_tab = 32'sd14667;
			5'd8: atan_tab = 32'sd7334;
			5'd9: atan_tab = 32'sd3667;
			5'd10: atan_tab = 32'sd1833;
			5'd11: atan_tab = 32'sd917;
			5'd12: atan_tab = 32'sd458;
			5'd13: atan_tab = 32'sd229;
			5'd14: atan_tab = 32'sd115;
			5'd15: atan_tab = 32'sd57;
			5'd16: atan_tab = 32'sd29;
			5'd17: atan_tab = 32'sd14;
			5'd18: atan_tab = 32'sd7;
			5'd19: atan_tab = 32'sd4;
			5'd20: atan_tab = 32'sd2;
			5'd21: atan_tab = 32'sd1;
			default: atan_tab = '0;
		endcase
	endfunction

	// one bit wider than an element: negated -1.0*2 and sy above 2.0 must fit
	typedef struct packed {
		logic signed [VW-1:0] y;
		logic signed [VW-1:0] x;
	} vec_t;
endpackage
`default_nettype wire

### src/rotation_matrix_to_euler.sv
`default_nettype none
// Rotation matrix (3x3, Q2.14) to Z-Y-X Euler angles in 1/128 degree.
// Input channel s_axis: nine elements in tdata, m00 lowest. Output m_axis:
// roll, pitch, yaw in tdata, tuser = {singular, not_rotation}.
// Config: cfg_we/cfg_idx/cfg_wdata; index 0 tolerance, 1 singular threshold.
// Pipeline: 4 check stages, 17 sqrt stages, CORDIC_STAGES+2 atan2 stages;
// one matrix per cycle sustained while the receiver does not stall the output.
// The whole pipeline advances only when the output register is free or taken,
// so a receiver stall holds every stage, losing nothing.
// Reset clears valid bits and loads register defaults (268, 1).
// Rejected matrices give zero angles and singular = 0.
module rotation_matrix_to_euler #(
	parameter int ELEMENT_WIDTH = 16,
	parameter int CORDIC_STAGES = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic s_axis_tvalid,
	output logic s_axis_tready,
	input  wire logic [((9*ELEMENT_WIDTH+7)/8)*8-1:0] s_axis_tdata, // m00..m22
	output logic m_axis_tvalid,
	input  wire logic m_axis_tready,
	output logic [47:0] m_axis_tdata, // roll_deg, pitch_deg, yaw_deg
	output logic [1:0] m_axis_tuser,  // not_rotation, singular
	input  wire logic cfg_we,
	input  wire logic [0:0] cfg_idx,
	input  wire logic [31:0] cfg_wdata
);
	import rme_pkg::*;

	localparam int LAT = 4 + 17 + CORDIC_STAGES + 2;

	logic [31:0] tol_q;
	logic [14:0] thr_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= 32'd268; thr_q <= 15'd1;
		end else if (cfg_we) begin
			if (5'(cfg_idx) == REG_TOL) tol_q <= cfg_wdata;
			else if (5'(cfg_idx) == REG_SING) thr_q <= cfg_wdata[14:0];
		end
	end

	logic en;
	logic [LAT-1:0] vld_q;
	assign en = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else if (en) vld_q <= {vld_q[LAT-2:0], s_axis_tvalid};
	end
	assign m_axis_tvalid = vld_q[LAT-1];

	logic bad, sing;
	vec_t vr, vp, vy;
	rme_front #(.EW(ELEMENT_WIDTH)) u_front (
		.clk, .en, .raw(s_axis_tdata[9*ELEMENT_WIDTH-1:0]), .tol(tol_q), .thr(thr_q),
		.bad, .sing, .v_roll(vr), .v_pitch(vp), .v_yaw(vy)
	);

	logic signed [15:0] a_r, a_p, a_y;
	rme_cordic #(.STAGES(CORDIC_STAGES)) u_roll (.clk, .en, .vin(vr), .ang(a_r));
	rme_cordic #(.STAGES(CORDIC_STAGES)) u_pitch (.clk, .en, .vin(vp), .ang(a_p));
	rme_cordic #(.STAGES(CORDIC_STAGES)) u_yaw (.clk, .en, .vin(vy), .ang(a_y));

	logic [CORDIC_STAGES+1:0] bad_d, sing_d;
	always_ff @(posedge clk) begin
		if (en) begin
			bad_d <= {bad_d[CORDIC_STAGES:0], bad};
			sing_d <= {sing_d[CORDIC_STAGES:0], sing && !bad};
		end
	end

	logic b_o, s_o;
	assign b_o = bad_d[CORDIC_STAGES+1];
	assign s_o = sing_d[CORDIC_STAGES+1];
	assign m_axis_tdata = {(b_o || s_o) ? 16'd0 : a_y, b_o ? 16'd0 : a_p, b_o ? 16'd0 : a_r};
	assign m_axis_tuser = {s_o, b_o};

`ifndef NO_ASSERTIONS
	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1])) else $error("flags both set");
	a_yaw: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser[1]) |-> m_axis_tdata[47:32] == 16'd0)
		else $error("yaw nonzero when singular");
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> $stable(vld_q)) else $error("pipe moved in stall");
`endif
endmodule
`default_nettype wire

### src/rme_cordic.sv
`default_nettype none
// Pipelined vectoring CORDIC atan2: y,x Q2.14 in, angle in 1/128 degree out.
// Input stage, rotation stages and output register; advances when en is high.
module rme_cordic #(
	parameter int STAGES = 16
) (
	input  wire logic clk,
	input  wire logic en,
	input  wire rme_pkg::vec_t vin,
	output logic signed [15:0] ang
);
	import rme_pkg::*;

	logic signed [CW-1:0] x_s [0:STAGES];
	logic signed [CW-1:0] y_s [0:STAGES];
	logic signed [ANG_W-1:0] z_s [0:STAGES];
	logic zero_s [0:STAGES];
	logic signed [CW-1:0] xi, yi;

	assign xi = CW'(vin.x) <<< Q14;
	assign yi = CW'(vin.y) <<< Q14;

	always_ff @(posedge clk) begin
		if (en) begin
			zero_s[0] <= (vin.x == '0) && (vin.y == '0);
			if (xi < 0) begin
				if (yi >= 0) begin
					x_s[0] <= yi; y_s[0] <= -xi; z_s[0] <= ANG_90;
				end else begin
					x_s[0] <= -yi; y_s[0] <= xi; z_s[0] <= -ANG_90;
				end
			end else begin
				x_s[0] <= xi; y_s[0] <= yi; z_s[0] <= '0;
			end
		end
	end

	for (genvar i = 0; i < STAGES; i++) begin : g_stage
		always_ff @(posedge clk) begin
			if (en) begin
				zero_s[i+1] <= zero_s[i];
				if (y_s[i] > 0) begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + atan_tab(5'(i));
				end else begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - atan_tab(5'(i));
				end
			end
		end
	end

	logic signed [ANG_W-1:0] zr;
	assign zr = (z_s[STAGES] + ANG_W'(128)) >>> 8;

	always_ff @(posedge clk) begin
		if (en) begin
			if (zero_s[STAGES]) ang <= '0;
			else if (zr > ANG_LIMIT) ang <= 16'(ANG_LIMIT);
			else if (zr < -ANG_LIMIT) ang <= 16'(-ANG_LIMIT);
			else ang <= 16'(zr);
		end
	end
endmodule
`default_nettype wire

### src/rme_front.sv
`default_nettype none
// Orthogonality check and sy square root (sqrt one root bit per stage).
module rme_front #(
	parameter int EW = 16
) (
	input  wire logic clk,
	input  wire logic en,
	input  wire logic [EW*9-1:0] raw,
	input  wire logic [31:0] tol,
	input  wire logic [14:0] thr,
	output logic bad,
	output logic sing,
	output rme_pkg::vec_t v_roll,
	output rme_pkg::vec_t v_pitch,
	output rme_pkg::vec_t v_yaw
);
	import rme_pkg::*;

	localparam int NS = 17; // sqrt steps over 34-bit operand

	logic signed [QW-1:0] m [0:8];
	for (genvar k = 0; k < 9; k++) begin : g_ld
		logic signed [EW-1:0] e;
		assign e = raw[k*EW +: EW];
		if (EW >= QW) begin : g_w
			logic signed [EW-1:0] sh;
			assign sh = e >>> (EW - QW);
			assign m[k] = QW'(sh);
		end else begin : g_n
			assign m[k] = QW'(e) <<< (QW - EW);
		end
	end

	// s1: register elements
	logic signed [QW-1:0] m_s1 [0:8];
	// s2: gram entries
	logic signed [QW-1:0] m_s2 [0:8];
	logic signed [34:0] g_s2 [0:8];
	// s3: squares
	logic signed [QW-1:0] m_s3 [0:8];
	logic [68:0] sq_s3 [0:8];
	// s4: sum and compare
	logic signed [QW-1:0] m_s4 [0:8];
	logic bad_s4;
	logic [33:0] n_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 9; k++) m_s1[k] <= m[k];
			for (int k = 0; k < 9; k++) m_s2[k] <= m_s1[k];
			for (int r = 0; r < 3; r++)
				for (int c = 0; c < 3; c++)
					g_s2[r*3+c] <= 35'(m_s1[r]) * 35'(m_s1[c])
						+ 35'(m_s1[3+r]) * 35'(m_s1[3+c])
						+ 35'(m_s1[6+r]) * 35'(m_s1[6+c])
						- ((r == c) ? 35'sd268435456 : 35'sd0);
			for (int k = 0; k < 9; k++) begin
				m_s3[k] <= m_s2[k];
				sq_s3[k] <= 69'((g_s2[k] < 0 ? -g_s2[k] : g_s2[k]))
					* 69'((g_s2[k] < 0 ? -g_s2[k] : g_s2[k]));
			end
			for (int k = 0; k < 9; k++) m_s4[k] <= m_s3[k];
		end
	end

	logic [72:0] tot;
	always_comb begin
		tot = '0;
		for (int k = 0; k < 9; k++) tot = tot + 73'(sq_s3[k]);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			bad_s4 <= (tot > 73'(64'hFFFF_FFFF_FFFF_FFFF) ? 73'(64'hFFFF_FFFF_FFFF_FFFF) : tot)
				> (73'(tol) << 28);
			n_s4 <= 34'(m_s3[0]) * 34'(m_s3[0]) + 34'(m_s3[3]) * 34'(m_s3[3]);
		end
	end

	// restoring sqrt pipeline, one result bit per stage
	logic [33:0] n_q [0:NS];
	logic [17:0] r_q [0:NS];
	logic b_q [0:NS];
	logic signed [QW-1:0] mq [0:NS][0:8];
	always_comb begin
		n_q[0] = n_s4; r_q[0] = '0; b_q[0] = bad_s4;
		for (int k = 0; k < 9; k++) mq[0][k] = m_s4[k];
	end
	for (genvar i = 0; i < NS; i++) begin : g_sq
		localparam int SH = 2*(NS-1-i);
		logic [35:0] trial;
		assign trial = 36'({r_q[i], 2'b01}) << SH;
		always_ff @(posedge clk) begin
			if (en) begin
				b_q[i+1] <= b_q[i];
				for (int k = 0; k < 9; k++) mq[i+1][k] <= mq[i][k];
				if (36'(n_q[i]) >= trial) begin
					n_q[i+1] <= 34'(36'(n_q[i]) - trial);
					r_q[i+1] <= {r_q[i][16:0], 1'b1};
				end else begin
					n_q[i+1] <= n_q[i];
					r_q[i+1] <= {r_q[i][16:0], 1'b0};
				end
			end
		end
	end

	logic [17:0] sy;
	logic sg;
	assign sy = r_q[NS];
	assign bad = b_q[NS];
	assign sg = (18'(thr) > sy);
	assign sing = sg;
	always_comb begin
		v_pitch.y = -VW'(mq[NS][6]);
		v_pitch.x = VW'(sy);
		if (sg) begin
			v_roll.y = -VW'(mq[NS][5]); v_roll.x = VW'(mq[NS][4]);
		end else begin
			v_roll.y = VW'(mq[NS][7]); v_roll.x = VW'(mq[NS][8]);
		end
		v_yaw.y = VW'(mq[NS][3]); v_yaw.x = VW'(mq[NS][0]);
	end
endmodule
`default_nettype wire
